>>> rtl/core/boiler_status_frame_parser_top_macros.svh
// assertion macros for the boiler status frame parser
// expects clk and rst_n in the scope of the module that uses them
`ifndef BOILER_STATUS_FRAME_PARSER_TOP_MACROS_SVH
`define BOILER_STATUS_FRAME_PARSER_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define BSFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BSFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/bsfp_pkg.sv
// shared types, constants and helpers for the boiler status frame parser
// no dependencies
`default_nettype none

package bsfp_pkg;

    localparam int DEF_MAX_ROOMS               = 8;
    localparam int DEF_MAX_PACKETS_PER_MESSAGE = 10;
    localparam int DEF_QUEUE_DEPTH             = 4;

    localparam logic [7:0] FRAME_START = 8'hF7;
    localparam logic [7:0] HDR_BYTE_1  = 8'h36;
    localparam logic [7:0] HDR_BYTE_2  = 8'h0F;
    localparam logic [7:0] HDR_BYTE_3  = 8'h81;
    localparam logic [7:0] LEN_BIAS    = 8'd5;

    localparam logic [8:0] POS_LENGTH     = 9'd4;
    localparam logic [8:0] POS_STATUS_LO  = 9'd5;
    localparam logic [8:0] POS_STATUS_HI  = 9'd9;
    localparam logic [8:0] POS_ROOMS      = 9'd10;
    localparam logic [8:0] POS_MAX        = 9'd511;

    localparam int STATUS_BYTES = 5;

    typedef enum logic [2:0] {
        SLOT_ERROR   = 3'd0,
        SLOT_HEAT    = 3'd1,
        SLOT_OUTSIDE = 3'd2,
        SLOT_RESERVE = 3'd3,
        SLOT_HOT     = 3'd4
    } slot_t;

    typedef enum logic [2:0] {
        RM_HEAT      = 3'd0,
        RM_OUTSIDE   = 3'd1,
        RM_RESERVE   = 3'd2,
        RM_HOT_WATER = 3'd3,
        RM_ERROR     = 3'd4,
        RM_OFF       = 3'd5
    } mode_t;

    typedef enum logic {
        OP_STATUS = 1'b0,
        OP_ROOM   = 1'b1
    } op_kind_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [2:0] room_index;
        logic [2:0] room_mode;
        logic [7:0] target_half_degrees;
        logic [7:0] current_half_degrees;
        logic       last_room;
    } out_item_t;

    // work item from the front to the back
    typedef struct packed {
        op_kind_t   kind;
        slot_t      slot;
        logic [2:0] idx;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic       last;
    } op_t;

    // expected header byte at frame positions one to three
    function automatic logic [7:0] hdr_byte(input logic [1:0] pos);
        logic [7:0] b;
        unique case (pos)
            2'd1:    b = HDR_BYTE_1;
            2'd2:    b = HDR_BYTE_2;
            2'd3:    b = HDR_BYTE_3;
            default: b = FRAME_START;
        endcase
        return b;
    endfunction

    // low seven bits doubled plus bit seven: a rotate left by one
    function automatic logic [7:0] half_degrees(input logic [7:0] b);
        return {b[6:0], b[7]};
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/bsfp_queue.sv
// short fifo of work items between the front and the back
// depends on bsfp_pkg and the assertion macro header
`default_nettype none
`include "boiler_status_frame_parser_top_macros.svh"

module bsfp_queue #(
    parameter int DEPTH = bsfp_pkg::DEF_QUEUE_DEPTH
) (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             push,
    input  bsfp_pkg::op_t   push_op,
    output logic            full,
    input  wire             pop,
    output logic            head_valid,
    output bsfp_pkg::op_t   head_op
);
    import bsfp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    op_t              entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_op    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    `BSFP_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_FULL, "queue count above depth")
    `BSFP_ASSERT_NOW(a_no_push_full, full, !push, "push into a full queue")
    `BSFP_ASSERT_NOW(a_no_pop_empty, pop, head_valid, "pop from an empty queue")
    `BSFP_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1,
        "queue count did not grow on push")

endmodule

`default_nettype wire

>>> rtl/core/bsfp_front.sv
// front end: framing, header check and byte classification
// depends on bsfp_pkg
`default_nettype none

module bsfp_front #(
    parameter int MAX_ROOMS               = bsfp_pkg::DEF_MAX_ROOMS,
    parameter int MAX_PACKETS_PER_MESSAGE = bsfp_pkg::DEF_MAX_PACKETS_PER_MESSAGE
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  bsfp_pkg::in_item_t  in_data,
    input  wire                 q_full,
    output logic                push,
    output bsfp_pkg::op_t       push_op
);
    import bsfp_pkg::*;

    localparam logic [3:0] MAX_PKTS  = 4'(MAX_PACKETS_PER_MESSAGE);
    localparam logic [6:0] ROOMS_CAP = 7'(MAX_ROOMS);

    logic       in_frame_reg, in_frame_next;
    logic       hdr_ok_reg, hdr_ok_next;
    logic [8:0] pos_reg, pos_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] held_reg, held_next;
    logic [3:0] frames_reg, frames_next;
    logic       halted_reg, halted_next;

    logic       accept;
    logic [7:0] b;
    logic [6:0] rooms;
    logic [6:0] limit;
    logic [8:0] rel;
    logic [7:0] idx;
    logic [7:0] len_off;
    logic [8:0] slot_off;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign b        = in_data.byte_value;

    // room count from the length byte, clamped at zero and at the room cap
    assign len_off  = len_reg - LEN_BIAS;
    assign rooms    = (len_reg >= LEN_BIAS) ? len_off[7:1] : '0;
    assign limit    = (rooms < ROOMS_CAP) ? rooms : ROOMS_CAP;
    assign rel      = pos_reg - POS_ROOMS;
    assign idx      = rel[8:1];
    assign slot_off = pos_reg - POS_STATUS_LO;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        hdr_ok_next   = hdr_ok_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        held_next     = held_reg;
        frames_next   = frames_reg;
        halted_next   = halted_reg;
        push          = 1'b0;
        push_op       = '{kind: OP_STATUS, slot: SLOT_ERROR, idx: idx[2:0],
                          byte_a: b, byte_b: b, last: 1'b0};

        if (accept)
        begin
            if (!halted_reg)
            begin
                if (b == FRAME_START)
                begin
                    if (frames_reg >= MAX_PKTS)
                    begin
                        halted_next   = 1'b1;
                        in_frame_next = 1'b0;
                    end
                    else
                    begin
                        frames_next   = frames_reg + 1'b1;
                        in_frame_next = 1'b1;
                        hdr_ok_next   = 1'b1;
                        pos_next      = 9'd1;
                    end
                end
                else if (in_frame_reg)
                begin
                    priority if (pos_reg < POS_LENGTH)
                    begin
                        if (pos_reg != '0 && b != hdr_byte(pos_reg[1:0]))
                        begin
                            hdr_ok_next = 1'b0;
                        end
                    end
                    else if (pos_reg == POS_LENGTH)
                    begin
                        len_next = b;
                    end
                    else if (pos_reg <= POS_STATUS_HI)
                    begin
                        push         = 1'b1;
                        push_op.kind = OP_STATUS;
                        push_op.slot = slot_t'(slot_off[2:0]);
                    end
                    else if (!rel[0])
                    begin
                        held_next = b;
                    end
                    else
                    begin
                        if (hdr_ok_reg && ({1'b0, idx} < {2'b00, limit}))
                        begin
                            push           = 1'b1;
                            push_op.kind   = OP_ROOM;
                            push_op.byte_a = held_reg;
                            push_op.last   = ({1'b0, idx} + 9'd1 == {2'b00, limit});
                        end
                    end
                    if (pos_reg != POS_MAX)
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            if (in_data.end_of_message)
            begin
                in_frame_next = 1'b0;
                hdr_ok_next   = 1'b0;
                pos_next      = '0;
                frames_next   = '0;
                halted_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            hdr_ok_reg   <= 1'b0;
            pos_reg      <= '0;
            frames_reg   <= '0;
            halted_reg   <= 1'b0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            hdr_ok_reg   <= hdr_ok_next;
            pos_reg      <= pos_next;
            frames_reg   <= frames_next;
            halted_reg   <= halted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg  <= len_next;
        held_reg <= held_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/bsfp_back.sv
// back end: status store, room mode decode and output register
// depends on bsfp_pkg
`default_nettype none

module bsfp_back (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  head_valid,
    input  bsfp_pkg::op_t        head_op,
    output logic                 pop,
    output logic                 out_valid,
    input  wire                  out_ready,
    output bsfp_pkg::out_item_t  out_data
);
    import bsfp_pkg::*;

    logic [7:0] status_reg [STATUS_BYTES];
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_data_reg;
    out_item_t  result;
    mode_t      mode;
    logic       room_pop;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // status writes drain at once; a room waits for a free output register
    assign pop      = head_valid &&
                      (head_op.kind == OP_STATUS || !out_valid_reg || out_ready);
    assign room_pop = pop && head_op.kind == OP_ROOM;

    always_comb
    begin
        priority if (status_reg[SLOT_ERROR] != '0)
            mode = RM_ERROR;
        else if (status_reg[SLOT_HEAT][head_op.idx])
            mode = RM_HEAT;
        else if (status_reg[SLOT_OUTSIDE][head_op.idx])
            mode = RM_OUTSIDE;
        else if (status_reg[SLOT_RESERVE][head_op.idx])
            mode = RM_RESERVE;
        else if (status_reg[SLOT_HOT][head_op.idx])
            mode = RM_HOT_WATER;
        else
            mode = RM_OFF;
    end

    always_comb
    begin
        result.room_index           = head_op.idx;
        result.room_mode            = mode;
        result.target_half_degrees  = half_degrees(head_op.byte_a);
        result.current_half_degrees = half_degrees(head_op.byte_b);
        result.last_room            = head_op.last;

        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (room_pop)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < STATUS_BYTES; i++)
            begin
                status_reg[i] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop && head_op.kind == OP_STATUS)
            begin
                unique case (head_op.slot)
                    SLOT_ERROR:   status_reg[SLOT_ERROR]   <= head_op.byte_a;
                    SLOT_HEAT:    status_reg[SLOT_HEAT]    <= head_op.byte_a;
                    SLOT_OUTSIDE: status_reg[SLOT_OUTSIDE] <= head_op.byte_a;
                    SLOT_RESERVE: status_reg[SLOT_RESERVE] <= head_op.byte_a;
                    SLOT_HOT:     status_reg[SLOT_HOT]     <= head_op.byte_a;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (room_pop)
        begin
            out_data_reg <= result;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/boiler_status_frame_parser_top.sv
// a room result is registered in the work queue, then in the output register
// throughput: one byte transaction per cycle while the work queue is not full, one room result per cycle out
// the front stalls only when the work queue (four entries by default) is full
// a stalled output register holds the queue at its first room; status writes ahead of it still drain
// reset: asynchronous, active low; framing, queue, status store and output valid clear at once
`default_nettype none

// top level of the boiler status frame parser
// depends on bsfp_pkg, bsfp_front, bsfp_queue and bsfp_back
module boiler_status_frame_parser_top #(
    parameter int MAX_ROOMS               = bsfp_pkg::DEF_MAX_ROOMS,
    parameter int MAX_PACKETS_PER_MESSAGE = bsfp_pkg::DEF_MAX_PACKETS_PER_MESSAGE,
    parameter int QUEUE_DEPTH             = bsfp_pkg::DEF_QUEUE_DEPTH
) (
    input  wire                  clk,
    input  wire                  rst_n,
    // byte stream in
    input  wire                  in_valid,
    output logic                 in_ready,
    input  bsfp_pkg::in_item_t   in_data,
    // room reports out
    output logic                 out_valid,
    input  wire                  out_ready,
    output bsfp_pkg::out_item_t  out_data
);
    import bsfp_pkg::*;

    // front to queue
    logic push;
    op_t  push_op;
    logic q_full;

    // queue to back
    logic pop;
    logic head_valid;
    op_t  head_op;

    // framing and classification: one decision per byte transaction
    bsfp_front #(
        .MAX_ROOMS              (MAX_ROOMS),
        .MAX_PACKETS_PER_MESSAGE(MAX_PACKETS_PER_MESSAGE)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data (in_data),
        .q_full  (q_full),
        .push    (push),
        .push_op (push_op)
    );

    // decouples the byte side from the result side
    bsfp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .full      (q_full),
        .pop       (pop),
        .head_valid(head_valid),
        .head_op   (head_op)
    );

    // status store update, mode decode and registered result
    bsfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(head_valid),
        .head_op   (head_op),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

>>> tb/sv/boiler_status_frame_parser_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the boiler status frame parser top level
// depends on bsfp_pkg and boiler_status_frame_parser_top; predicts every room report in place

module boiler_status_frame_parser_top_tb;

    import bsfp_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    localparam int ROOM_CAP       = DEF_MAX_ROOMS;
    localparam int FRAME_CAP      = DEF_MAX_PACKETS_PER_MESSAGE;
    localparam int RANDOM_ITEMS   = 770;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 3000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    // rooms predicted but not yet seen at the output, oldest first
    out_item_t expected_rooms[$];
    int        fails = 0;
    int        random_items = 0;

    // idling control shared by both sides
    bit        no_idle = 1'b0;
    bit        long_hold_req = 1'b0;
    bit        room_taken = 1'b0;

    // shadow copy of the parser state
    logic       frm_open = 1'b0;
    logic       hdr_ok = 1'b0;
    logic [8:0] frm_pos = '0;
    logic [7:0] len_byte = '0;
    logic [7:0] status_bytes [STATUS_BYTES] = '{default: '0};
    logic [7:0] target_byte = '0;
    logic [3:0] frame_count = '0;
    logic       msg_stopped = 1'b0;

    boiler_status_frame_parser_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial begin : clock_gen
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // temperature byte: low seven bits are whole degrees, bit seven adds a half
    function automatic logic [7:0] to_half_degrees(input logic [7:0] b);
        return {b[6:0], 1'b0} | {7'd0, b[7]};
    endfunction

    // error byte wins outright, then the first status byte with the room's bit set
    function automatic mode_t mode_for(input logic [2:0] idx);
        if (status_bytes[SLOT_ERROR] != 8'h00) return RM_ERROR;
        if (status_bytes[SLOT_HEAT][idx])      return RM_HEAT;
        if (status_bytes[SLOT_OUTSIDE][idx])   return RM_OUTSIDE;
        if (status_bytes[SLOT_RESERVE][idx])   return RM_RESERVE;
        if (status_bytes[SLOT_HOT][idx])       return RM_HOT_WATER;
        return RM_OFF;
    endfunction

    // advance the shadow state by one accepted byte, queueing any room it completes
    task automatic predict_rooms(input logic [7:0] b, input logic eom);
        int unsigned rel;
        int unsigned pair;
        int unsigned rooms;
        int unsigned cap;
        logic [7:0]  hdr_want;
        out_item_t   room;
        if (!msg_stopped) begin
            if (b == FRAME_START) begin
                // a frame start past the per-message cap silences the rest of the message
                if (frame_count >= FRAME_CAP) begin
                    msg_stopped = 1'b1;
                    frm_open    = 1'b0;
                end
                else begin
                    frame_count = frame_count + 4'd1;
                    frm_open    = 1'b1;
                    hdr_ok      = 1'b1;
                    frm_pos     = 9'd1;
                end
            end
            else if (frm_open) begin
                if (frm_pos < POS_LENGTH) begin
                    case (frm_pos[1:0])
                        2'd1:    hdr_want = HDR_BYTE_1;
                        2'd2:    hdr_want = HDR_BYTE_2;
                        default: hdr_want = HDR_BYTE_3;
                    endcase
                    if (b != hdr_want) hdr_ok = 1'b0;
                end
                else if (frm_pos == POS_LENGTH) begin
                    len_byte = b;
                end
                else if (frm_pos <= POS_STATUS_HI) begin
                    status_bytes[frm_pos - POS_STATUS_LO] = b;
                end
                else begin
                    rel   = frm_pos - POS_ROOMS;
                    rooms = (len_byte >= LEN_BIAS) ? (len_byte - LEN_BIAS) / 2 : 0;
                    cap   = (rooms < ROOM_CAP) ? rooms : ROOM_CAP;
                    pair  = rel >> 1;
                    if (rel[0] == 1'b0) begin
                        target_byte = b;
                    end
                    else if (hdr_ok && pair < cap) begin
                        room.room_index           = 3'(pair);
                        room.room_mode            = mode_for(3'(pair));
                        room.target_half_degrees  = to_half_degrees(target_byte);
                        room.current_half_degrees = to_half_degrees(b);
                        room.last_room            = (pair + 1 == cap);
                        expected_rooms.push_back(room);
                    end
                end
                // position counter sticks at its top value on very long frames
                if (frm_pos != POS_MAX) frm_pos = frm_pos + 9'd1;
            end
        end
        // end of message clears the framing after the byte itself is handled
        if (eom) begin
            frm_open    = 1'b0;
            hdr_ok      = 1'b0;
            frm_pos     = '0;
            frame_count = '0;
            msg_stopped = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // byte sender: drives at the falling edge, sees acceptance at the rising edge
    // ------------------------------------------------------------------

    task automatic send_byte(input logic [7:0] b, input logic eom);
        int idle;
        idle = no_idle ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        if (idle > 0) begin
            in_valid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        in_data  <= '{byte_value: b, end_of_message: eom};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_rooms(b, eom);
    endtask

    // send a run of bytes, flagging the last one as end of message when asked
    task automatic send_bytes(input byte_q_t seq, input bit close);
        for (int i = 0; i < seq.size(); i++)
            send_byte(seq[i], close && (i == seq.size() - 1));
    endtask

    // mostly anything but a frame start, which turns up now and then on purpose
    function automatic logic [7:0] data_byte();
        logic [7:0] b;
        if ($urandom_range(0, 63) == 0) return FRAME_START;
        b = 8'($urandom);
        if (b == FRAME_START) b = 8'h00;
        return b;
    endfunction

    // ------------------------------------------------------------------
    // result checking and receiver
    // ------------------------------------------------------------------

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fails++;
        end
    endtask

    initial begin : room_checker
        out_item_t want;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                room_taken = 1'b1;
                if (expected_rooms.size() == 0) begin
                    $error("room report with nothing expected: room_index %0d",
                           out_data.room_index);
                    fails++;
                end
                else begin
                    want = expected_rooms.pop_front();
                    compare_field("room_index", want.room_index, out_data.room_index);
                    compare_field("room_mode", want.room_mode, out_data.room_mode);
                    compare_field("target_half_degrees", want.target_half_degrees,
                                  out_data.target_half_degrees);
                    compare_field("current_half_degrees", want.current_half_degrees,
                                  out_data.current_half_degrees);
                    compare_field("last_room", want.last_room, out_data.last_room);
                end
            end
        end
    end

    // after each taken room draw a stall; a long hold-off is served on request
    initial begin : room_receiver
        int stall;
        stall     = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                stall = 0;
            end
            if (room_taken) begin
                room_taken = 1'b0;
                stall = no_idle ? 0 : $urandom_range(0, 12);
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                stall--;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ends the run if neither channel completes a transaction for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
            else quiet++;
        end
        $display("boiler_status_frame_parser_top verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // five rooms: one per mode bit plus one with nothing set, temperature extremes
    task automatic test_room_modes();
        send_bytes('{FRAME_START, HDR_BYTE_1, HDR_BYTE_2, HDR_BYTE_3, 8'd15,
                     8'h00, 8'h01, 8'h02, 8'h04, 8'h08,
                     8'h00, 8'hFF, 8'h7F, 8'h80, 8'hFE, 8'h01, 8'h55, 8'hAA,
                     8'h81, 8'h3C}, 1'b1);
    endtask

    // nonzero error byte overrides every bit, then a frame with a wrong header byte
    task automatic test_error_and_bad_header();
        send_bytes('{FRAME_START, HDR_BYTE_1, HDR_BYTE_2, HDR_BYTE_3, 8'd7,
                     8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'hFE,
                     FRAME_START, HDR_BYTE_1, 8'h0E, HDR_BYTE_3, 8'd7,
                     8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h11, 8'h22}, 1'b1);
    endtask

    // leading noise, length under five, odd length, frame cut by a frame start
    // inside a pair, and trailing bytes past the last counted room
    task automatic test_framing_edges();
        send_bytes('{8'h12, 8'h34,
                     FRAME_START, HDR_BYTE_1, HDR_BYTE_2, HDR_BYTE_3, 8'd4,
                     8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAA, 8'hBB,
                     FRAME_START, HDR_BYTE_1, HDR_BYTE_2, HDR_BYTE_3, 8'd12,
                     8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h10, 8'h20, 8'h30,
                     FRAME_START, HDR_BYTE_1, HDR_BYTE_2, HDR_BYTE_3, 8'd7,
                     8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h40, 8'h50, 8'h60, 8'h70},
                   1'b1);
    endtask

    // frame starts up to the cap, then one more halts the message until its end;
    // the following message is parsed again from scratch
    task automatic test_frame_cap();
        byte_q_t seq;
        repeat (FRAME_CAP) seq.push_back(FRAME_START);
        send_bytes(seq, 1'b0);
        send_bytes('{FRAME_START, FRAME_START, HDR_BYTE_1, HDR_BYTE_2, HDR_BYTE_3, 8'd7,
                     8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h11, 8'h22}, 1'b1);
        send_bytes('{FRAME_START, HDR_BYTE_1, HDR_BYTE_2, HDR_BYTE_3, 8'd7,
                     8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h33, 8'h44}, 1'b1);
    endtask

    // maximum length byte and far more data than the position counter can track
    task automatic test_long_frame();
        byte_q_t seq;
        seq = '{FRAME_START, HDR_BYTE_1, HDR_BYTE_2, HDR_BYTE_3, 8'hFF,
                8'h00, 8'hAA, 8'h55, 8'h0F, 8'hF0};
        repeat (520) seq.push_back(8'($urandom_range(0, 8'hF6)));
        send_bytes(seq, 1'b1);
    endtask

    // receiver holds off for a long time while full frames keep arriving back to back,
    // so the work queue fills and the input has to stall
    task automatic test_output_backpressure();
        byte_q_t seq;
        long_hold_req = 1'b1;
        no_idle       = 1'b1;
        repeat (3) begin
            seq = '{FRAME_START, HDR_BYTE_1, HDR_BYTE_2, HDR_BYTE_3, 8'd21,
                    8'h00, 8'hF0, 8'h0F, 8'h33, 8'hCC};
            repeat (2 * ROOM_CAP) seq.push_back(8'($urandom_range(0, 8'hF6)));
            send_bytes(seq, 1'b1);
        end
        no_idle = 1'b0;
    endtask

    // one random frame: mostly well formed, sometimes a bad header byte, odd or
    // out-of-range length, extra bytes, or cut short
    task automatic add_random_frame(ref byte_q_t msg);
        logic [7:0] len;
        int         rooms;
        int         pairs;
        int         keep;
        int         bad_pos;
        byte_q_t    body;
        bad_pos = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
        msg.push_back(FRAME_START);
        msg.push_back((bad_pos == 1) ? data_byte() : HDR_BYTE_1);
        msg.push_back((bad_pos == 2) ? data_byte() : HDR_BYTE_2);
        msg.push_back((bad_pos == 3) ? data_byte() : HDR_BYTE_3);
        case ($urandom_range(0, 7))
            0:       len = data_byte();
            1:       len = 8'($urandom_range(0, 4));
            default: len = 8'(5 + 2 * $urandom_range(0, 8) + $urandom_range(0, 1));
        endcase
        rooms = (len >= LEN_BIAS) ? (len - LEN_BIAS) / 2 : 0;
        pairs = (rooms < ROOM_CAP) ? rooms : ROOM_CAP;
        body.push_back(len);
        body.push_back(($urandom_range(0, 3) == 0) ? data_byte() : 8'h00);
        // sparse status bits so that every mode shows up
        repeat (STATUS_BYTES - 1) body.push_back(8'($urandom & $urandom));
        repeat (2 * pairs) body.push_back(data_byte());
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) body.push_back(data_byte());
        keep = body.size();
        if ($urandom_range(0, 7) == 0) keep = $urandom_range(0, body.size() - 1);
        for (int i = 0; i < keep; i++) msg.push_back(body[i]);
    endtask

    // whole messages of random frames, some past the frame cap, some pure noise
    task automatic test_random_messages();
        byte_q_t msg;
        int      frames;
        while (random_items < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 5) == 0);
            msg.delete();
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) msg.push_back(data_byte());
            frames = ($urandom_range(0, 5) == 0) ? $urandom_range(FRAME_CAP, FRAME_CAP + 2)
                                                 : $urandom_range(0, 4);
            repeat (frames) add_random_frame(msg);
            if (msg.size() == 0) msg.push_back(data_byte());
            send_bytes(msg, 1'b1);
            random_items += msg.size();
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin : test_sequence
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_room_modes();
        test_error_and_bad_header();
        test_framing_edges();
        test_frame_cap();
        test_long_frame();
        test_output_backpressure();
        test_random_messages();

        @(negedge clk);
        in_valid <= 1'b0;
        // a leftover expectation keeps this loop waiting until the watchdog fires
        while (expected_rooms.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fails == 0)
            $display("boiler_status_frame_parser_top verification clean");
        else
            $display("boiler_status_frame_parser_top verification failed");
        $finish;
    end

endmodule

>>> boiler_status_frame_parser_top.f
+incdir+rtl/core
rtl/core/bsfp_pkg.sv
rtl/core/bsfp_queue.sv
rtl/core/bsfp_front.sv
rtl/core/bsfp_back.sv
rtl/core/boiler_status_frame_parser_top.sv
tb/sv/boiler_status_frame_parser_top_tb.sv
